FILE: rtl/core/masked_byte_pattern_search_defines.svh
// assertion macros used by masked_byte_pattern_search.sv
`ifndef MASKED_BYTE_PATTERN_SEARCH_DEFINES_SVH
`define MASKED_BYTE_PATTERN_SEARCH_DEFINES_SVH

// same-cycle implication, off during reset
`define MBPS_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mbps same-cycle check failed");

// next-cycle implication, off during reset
`define MBPS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mbps next-cycle check failed");

`endif

FILE: rtl/core/mbps_pkg.sv
`timescale 1ns / 1ps
package mbps_pkg;

  localparam int MAX_PATTERN_BYTES_DEF = 16;
  localparam int OFFSET_BITS_DEF       = 32;

  localparam int OFFSET_OUT_W = 32;
  localparam int PAT_REG_W    = 64;
  localparam int CARE_W       = 16;
  localparam int LEN_REG_W    = 5;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 64;
  localparam int BYTE_W       = 8;

  localparam logic [LEN_REG_W-1:0] LEN_RESET  = LEN_REG_W'(16);
  localparam logic [CARE_W-1:0]    CARE_RESET = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PATTERN_LOW    = 2'd0,
    CFG_PATTERN_HIGH   = 2'd1,
    CFG_CARE_MASK      = 2'd2,
    CFG_PATTERN_LENGTH = 2'd3
  } cfg_reg_t;

endpackage

FILE: rtl/core/mbps_in_if.sv
`timescale 1ns / 1ps
interface mbps_in_if;
  logic                           valid;
  logic                           ready;
  logic [mbps_pkg::BYTE_W-1:0]    data_byte;
  logic                           last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

FILE: rtl/core/mbps_out_if.sv
`timescale 1ns / 1ps
interface mbps_out_if;
  logic                                valid;
  logic                                ready;
  logic                                found;
  logic [mbps_pkg::OFFSET_OUT_W-1:0]   match_offset;

  modport source (output valid, output found, output match_offset, input ready);
  modport sink   (input valid, input found, input match_offset, output ready);
endinterface

FILE: rtl/core/masked_byte_pattern_search.sv
`timescale 1ns / 1ps
// channel   modport  payload                      role
// in_ch     sink     data_byte[7:0], last_byte    buffer bytes, last closes buffer
// out_ch    source   found, match_offset[31:0]    one result per buffer at most
//
// one byte accepted per cycle unless a held result stalls input; the cell row compares the whole
// window in the cycle the byte is accepted
// the result is registered and shows on out_ch in the cycle after its byte
// in_ch.ready = !out_ch.valid || out_ch.ready; a held result stalls input
// rst is synchronous, active high; no clearing pass, ready low in reset and
// high right after
// config writes take effect on the next accepted byte
`include "masked_byte_pattern_search_defines.svh"
module masked_byte_pattern_search #(
  parameter int MAX_PATTERN_BYTES = mbps_pkg::MAX_PATTERN_BYTES_DEF,
  parameter int OFFSET_BITS       = mbps_pkg::OFFSET_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [mbps_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mbps_pkg::CFG_DATA_W-1:0]    cfg_data,
  mbps_in_if.sink                            in_ch,
  mbps_out_if.source                         out_ch
);
  localparam int MAX    = MAX_PATTERN_BYTES;
  localparam int LEN_W  = $clog2(MAX + 1);
  localparam int OUT_W  = mbps_pkg::OFFSET_OUT_W;
  localparam int DIFF_W = (OFFSET_BITS > OUT_W) ? OFFSET_BITS : OUT_W;

  // configuration registers
  logic [mbps_pkg::PAT_REG_W-1:0] pattern_low;
  logic [mbps_pkg::PAT_REG_W-1:0] pattern_high;
  logic [mbps_pkg::CARE_W-1:0]    care_mask;
  logic [mbps_pkg::LEN_REG_W-1:0] pattern_length;

  // scan state
  logic [OFFSET_BITS-1:0] bytes_seen;
  logic                   already_matched;

  // result register
  logic             out_valid;
  logic             out_found;
  logic [OUT_W-1:0] out_offset;

  logic in_acc;
  logic [LEN_W-1:0] len_eff;
  logic [OFFSET_BITS-1:0] count;
  logic [DIFF_W-1:0] diff_wide;
  logic window_full;
  logic hit;
  logic emit;

  logic [2*mbps_pkg::PAT_REG_W-1:0]          pat_all;
  logic [MAX-1:0][mbps_pkg::BYTE_W-1:0]      pattern;
  logic [MAX-1:0]                            cell_ok;
  logic [MAX-1:0][mbps_pkg::BYTE_W-1:0]      chain;

  // config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_low    <= '0;
      pattern_high   <= '0;
      care_mask      <= mbps_pkg::CARE_RESET;
      pattern_length <= mbps_pkg::LEN_RESET;
    end else if (cfg_we) begin
      unique case (mbps_pkg::cfg_reg_t'(cfg_index))
        mbps_pkg::CFG_PATTERN_LOW:    pattern_low    <= cfg_data;
        mbps_pkg::CFG_PATTERN_HIGH:   pattern_high   <= cfg_data;
        mbps_pkg::CFG_CARE_MASK:      care_mask      <= cfg_data[mbps_pkg::CARE_W-1:0];
        mbps_pkg::CFG_PATTERN_LENGTH: pattern_length <= cfg_data[mbps_pkg::LEN_REG_W-1:0];
        default: ;
      endcase
    end
  end

  // pattern bytes, byte 0 in the low byte of pattern_low
  assign pat_all = {pattern_high, pattern_low};
  generate
    for (genvar p = 0; p < MAX; p++) begin : g_pat
      assign pattern[p] = pat_all[mbps_pkg::BYTE_W*p +: mbps_pkg::BYTE_W];
    end
  endgenerate

  // length clamped to 1..MAX
  always_comb begin
    priority if (pattern_length == '0) begin
      len_eff = LEN_W'(1);
    end else if (pattern_length > mbps_pkg::LEN_REG_W'(MAX)) begin
      len_eff = LEN_W'(MAX);
    end else begin
      len_eff = LEN_W'(pattern_length);
    end
  end

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign in_ch.ready = !rst && (!out_valid || out_ch.ready);

  // row of cells: cell k sees the byte k positions back, current byte first
  assign chain[0] = in_ch.data_byte;
  generate
    for (genvar k = 0; k < MAX; k++) begin : g_cell
      if (k < MAX - 1) begin : g_mid
        mbps_cell #(.K(k), .MAX(MAX), .HOLD(1'b1)) u_cell (
          .clk       (clk),
          .shift_en  (in_acc),
          .shift_in  (chain[k]),
          .shift_out (chain[k+1]),
          .pattern   (pattern),
          .care      (care_mask[MAX-1:0]),
          .len_eff   (len_eff),
          .ok        (cell_ok[k])
        );
      end else begin : g_tail
        mbps_cell #(.K(k), .MAX(MAX), .HOLD(1'b0)) u_cell (
          .clk       (clk),
          .shift_en  (in_acc),
          .shift_in  (chain[k]),
          .shift_out (),
          .pattern   (pattern),
          .care      (care_mask[MAX-1:0]),
          .len_eff   (len_eff),
          .ok        (cell_ok[k])
        );
      end
    end
  endgenerate

  // saturating byte count including the current byte
  always_comb begin
    count       = (bytes_seen == '1) ? bytes_seen : bytes_seen + OFFSET_BITS'(1);
    window_full = count >= OFFSET_BITS'(len_eff);
    diff_wide   = DIFF_W'(count) - DIFF_W'(len_eff);
    hit         = window_full && (&cell_ok);
    emit        = in_acc && !already_matched && (hit || in_ch.last_byte);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_seen      <= '0;
      already_matched <= 1'b0;
    end else if (in_acc) begin
      if (in_ch.last_byte) begin
        // buffer ends, next byte starts a fresh one
        bytes_seen      <= '0;
        already_matched <= 1'b0;
      end else if (!already_matched) begin
        bytes_seen <= count;
        if (hit) begin
          already_matched <= 1'b1;
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_found  <= hit;
      out_offset <= hit ? diff_wide[OUT_W-1:0] : '0;
    end
  end

  assign out_ch.valid        = out_valid;
  assign out_ch.found        = out_found;
  assign out_ch.match_offset = out_offset;

  `MBPS_ASSERT_NEXT(a_last_clears, clk, rst, in_acc && in_ch.last_byte, (bytes_seen == '0) && !already_matched)
  `MBPS_ASSERT_NOW(a_notfound_zero, clk, rst, out_valid && !out_found, out_offset == '0)
  `MBPS_ASSERT_NEXT(a_hit_sticks, clk, rst, in_acc && hit && !already_matched && !in_ch.last_byte, already_matched)
  `MBPS_ASSERT_NOW(a_stall_blocks, clk, rst, out_valid && !out_ch.ready, !in_ch.ready)
  `MBPS_ASSERT_NEXT(a_matched_quiet, clk, rst, in_acc && already_matched && !in_ch.last_byte, bytes_seen == $past(bytes_seen))
endmodule

FILE: rtl/core/mbps_cell.sv
`timescale 1ns / 1ps
// one window slot: compares the byte arriving on shift_in against the
// pattern byte aligned to its distance back and, when HOLD is set, keeps it for the next cell
module mbps_cell #(
  parameter int K    = 0,
  parameter int MAX  = mbps_pkg::MAX_PATTERN_BYTES_DEF,
  parameter bit HOLD = 1'b1
) (
  input  logic                                       clk,
  input  logic                                       shift_en,
  input  logic [mbps_pkg::BYTE_W-1:0]                shift_in,
  output logic [mbps_pkg::BYTE_W-1:0]                shift_out,
  input  logic [MAX-1:0][mbps_pkg::BYTE_W-1:0]       pattern,
  input  logic [MAX-1:0]                             care,
  input  logic [$clog2(MAX+1)-1:0]                   len_eff,
  output logic                                       ok
);
  localparam int LEN_W = $clog2(MAX + 1);
  localparam int IDX_W = (MAX > 1) ? $clog2(MAX) : 1;

  logic             in_use;
  logic [LEN_W-1:0] j_wide;
  logic [IDX_W-1:0] j;

  always_comb begin
    in_use = LEN_W'(K) < len_eff;
    j_wide = len_eff - LEN_W'(K + 1);
    j      = j_wide[IDX_W-1:0];
    ok     = !(in_use && care[j]) || (shift_in == pattern[j]);
  end

  generate
    if (HOLD) begin : g_hold
      logic [mbps_pkg::BYTE_W-1:0] held;
      always_ff @(posedge clk) begin
        if (shift_en) begin
          held <= shift_in;
        end
      end
      assign shift_out = held;
    end else begin : g_end
      assign shift_out = '0;
    end
  endgenerate
endmodule
